>>> hdl/b64d_pkg.sv
package b64d_pkg;

  localparam int unsigned CMD_DEPTH = 4;

  localparam logic [15:0] CODE_LOW  = 16'd43;
  localparam logic [15:0] CODE_HIGH = 16'd132;
  localparam logic [15:0] PAD_CHAR  = 16'd61;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // one entry between front and back: up to three data bytes, then maybe a status
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  nbytes;
    logic        has_status;
    logic        err;
  } cmd_t;

  function automatic logic is_space(input logic [15:0] c);
    return (c == 16'd32) || (c == 16'd10) || (c == 16'd13) || (c == 16'd9);
  endfunction

  function automatic logic [5:0] sextet_of(input logic [15:0] c);
    logic [5:0] v;
    v = 6'd0;
    if (c >= 16'd65 && c <= 16'd90)       v = 6'(c - 16'd65);
    else if (c >= 16'd97 && c <= 16'd122) v = 6'(c - 16'd71);
    else if (c >= 16'd48 && c <= 16'd57)  v = 6'(c + 16'd4);
    else if (c == 16'd43)                 v = 6'd62;
    else if (c == 16'd47)                 v = 6'd63;
    return v;
  endfunction

endpackage

>>> hdl/base64_stream_decoder.sv
// Streaming base64 decoder (A-Z a-z 0-9 + /) for 16-bit text code units.
// Takes one character per clock when not full; whitespace between quads
// is skipped, and each quad yields three bytes, released when the next quad
// completes or at the end marker, where '=' padding trims them and a status
// word (kind 1 ok, kind 2 error, last set) closes the text. On error the
// consumer drops bytes already delivered. The front decodes characters and
// writes one entry per result-producing character into a CMD_DEPTH-deep
// queue; the back reads out one word per clock on pop, so a quad gives three
// words and an end up to four. Port full rises only when the queue is full.
module base64_stream_decoder #(
  parameter int unsigned CMD_DEPTH = b64d_pkg::CMD_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_code,
  input  logic        in_is_end,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic        out_last
);

  b64d_pkg::cmd_t f_cmd, q_cmd;
  logic           f_valid, take, q_empty, q_pop;

  assign take = push & ~full;

  b64d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .code      (in_code),
    .is_end    (in_is_end),
    .cmd_valid (f_valid),
    .cmd       (f_cmd)
  );

  b64d_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (take & f_valid),
    .wr_data (f_cmd),
    .rd_en   (q_pop),
    .rd_data (q_cmd),
    .full    (full),
    .empty   (q_empty)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last)
  );

endmodule

>>> hdl/b64d_front.sv
module b64d_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [15:0]         code,
  input  logic                is_end,
  output logic                cmd_valid,
  output b64d_pkg::cmd_t      cmd
);

  logic [17:0] accum_r, accum_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [23:0] held_r, held_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        err_r, err_nxt;

  logic        err_end;
  logic [5:0]  v;
  logic        eq;
  logic [1:0]  keep;

  always_comb begin
    accum_nxt      = accum_r;
    pos_nxt        = pos_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    pad_nxt        = pad_r;
    err_nxt        = err_r;
    cmd_valid      = 1'b0;
    cmd.bytes      = held_r;
    cmd.nbytes     = 2'd0;
    cmd.has_status = 1'b0;
    cmd.err        = 1'b0;

    v       = b64d_pkg::sextet_of(code);
    eq      = (code == b64d_pkg::PAD_CHAR);
    err_end = err_r | (pos_r != 2'd0);
    keep    = (pad_r[1]) ? 2'd1 : 2'(2'd3 - pad_r);

    if (is_end) begin
      cmd_valid      = 1'b1;
      cmd.has_status = 1'b1;
      cmd.err        = err_end;
      cmd.nbytes     = (!err_end && held_valid_r) ? keep : 2'd0;
      accum_nxt      = '0;
      pos_nxt        = '0;
      held_nxt       = '0;
      held_valid_nxt = 1'b0;
      pad_nxt        = '0;
      err_nxt        = 1'b0;
    end else if (err_r || (pos_r == 2'd0 && b64d_pkg::is_space(code))) begin
      // ignored
    end else if (code < b64d_pkg::CODE_LOW || code > b64d_pkg::CODE_HIGH) begin
      err_nxt        = 1'b1;
      held_valid_nxt = 1'b0;
    end else if (pos_r != 2'd3) begin
      accum_nxt = {accum_r[11:0], v};
      if (pos_r == 2'd2) pad_nxt = {1'b0, eq};
      pos_nxt = pos_r + 2'd1;
    end else begin
      if (held_valid_r) begin
        cmd_valid  = 1'b1;
        cmd.nbytes = 2'd3;
      end
      held_nxt       = {accum_r, v};
      held_valid_nxt = 1'b1;
      pad_nxt        = pad_r + {1'b0, eq};
      accum_nxt      = '0;
      pos_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r      <= '0;
      pos_r        <= '0;
      held_r       <= '0;
      held_valid_r <= 1'b0;
      pad_r        <= '0;
      err_r        <= 1'b0;
    end else if (take) begin
      accum_r      <= accum_nxt;
      pos_r        <= pos_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      pad_r        <= pad_nxt;
      err_r        <= err_nxt;
    end
  end

endmodule

>>> hdl/b64d_cmd_fifo.sv
module b64d_cmd_fifo #(
  parameter int unsigned DEPTH = b64d_pkg::CMD_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  b64d_pkg::cmd_t wr_data,
  input  logic           rd_en,
  output b64d_pkg::cmd_t rd_data,
  output logic           full,
  output logic           empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64d_pkg::cmd_t   mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == LAST) ? '0 : wp_r + AW'(1);
      if (do_rd) rp_r <= (rp_r == LAST) ? '0 : rp_r + AW'(1);
      if (do_wr && !do_rd) cnt_r <= cnt_r + CW'(1);
      else if (do_rd && !do_wr) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

>>> hdl/b64d_back.sv
module b64d_back (
  input  logic           clk,
  input  logic           rst_n,
  input  b64d_pkg::cmd_t cmd,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     out_byte,
  output logic [1:0]     out_kind,
  output logic           out_last
);

  logic [1:0] idx_r, idx_nxt;
  logic       is_data;
  logic       take;

  assign is_data = (idx_r < cmd.nbytes);
  assign empty   = cmd_empty;
  assign take    = pop & ~cmd_empty;

  always_comb begin
    case (idx_r)
      2'd0:    out_byte = cmd.bytes[23:16];
      2'd1:    out_byte = cmd.bytes[15:8];
      2'd2:    out_byte = cmd.bytes[7:0];
      default: out_byte = 8'd0;
    endcase
    if (!is_data) out_byte = 8'd0;
    out_kind = is_data ? b64d_pkg::KIND_DATA
             : (cmd.err ? b64d_pkg::KIND_ERR : b64d_pkg::KIND_OK);
    out_last = ~is_data;
  end

  // entry retires after its last data byte, or after its status word
  always_comb begin
    cmd_pop = 1'b0;
    idx_nxt = idx_r;
    if (take) begin
      if (!is_data || (idx_r + 2'd1 == cmd.nbytes && !cmd.has_status)) begin
        cmd_pop = 1'b1;
        idx_nxt = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else        idx_r <= idx_nxt;
  end

endmodule
